// ===== sv/strdec_pkg.sv =====
// Shared types, constants and character helpers for the string escape decoder.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps

package strdec_pkg;

  // One raw character of a literal body, as taken by the input queue port.
  typedef struct packed {
    logic [7:0] in_char;
    logic       has_char;
    logic       last;
  } in_item_t;

  // One decoded result, as shown on the output queue port.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       failed;
  } out_item_t;

  // Escape parser state.
  typedef enum logic [2:0] {
    ModeIdle = 3'd0,
    ModeEsc  = 3'd1,
    ModeOct  = 3'd2,
    ModeHex0 = 3'd3,
    ModeHex1 = 3'd4
  } mode_e;

  // Command handed from front to back: up to two bytes and an end marker.
  typedef struct packed {
    logic       b0_vld;
    logic [7:0] b0;
    logic       b1_vld;
    logic [7:0] b1;
    logic       end_vld;
    logic       fail;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharX      = 8'h78;
  localparam logic [1:0] LastOctIdx = 2'd2;

  function automatic logic is_octal(input logic [7:0] c);
    is_octal = (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r = '0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic esc_t simple_escape(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    case (c)
      8'h61:   r.val = 8'h07;  // a
      8'h62:   r.val = 8'h08;  // b
      8'h66:   r.val = 8'h0C;  // f
      8'h6E:   r.val = 8'h0A;  // n
      8'h72:   r.val = 8'h0D;  // r
      8'h74:   r.val = 8'h09;  // t
      8'h76:   r.val = 8'h0B;  // v
      8'h5C:   r.val = 8'h5C;  // backslash
      8'h27:   r.val = 8'h27;  // single quote
      8'h22:   r.val = 8'h22;  // double quote
      8'h3F:   r.val = 8'h3F;  // question mark
      default: begin
        r.ok  = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== sv/strdec_front.sv =====
// Front end: takes one character per cycle while accepted, tracks escape
// state; one command per item at most, up to three results. Uses strdec_pkg.
`timescale 1ns / 1ps

module strdec_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  strdec_pkg::in_item_t item_i,
  input  logic                 accept_i,
  output logic                 cmd_push_o,
  output strdec_pkg::cmd_t     cmd_o
);

  strdec_pkg::mode_e mode_q, mode_d, tk_mode;
  logic [7:0]        pv_q, pv_d, tk_pv;
  logic [1:0]        dt_q, dt_d, tk_dt;
  logic              err_q, err_d, tk_err;

  logic [7:0]        c;
  logic              c_oct;
  logic              c_bslash;
  strdec_pkg::hex_t  c_hex;
  strdec_pkg::esc_t  c_esc;
  strdec_pkg::cmd_t  cmd;

  assign c        = item_i.in_char;
  assign c_oct    = strdec_pkg::is_octal(c);
  assign c_bslash = (c == strdec_pkg::CharBslash);
  assign c_hex    = strdec_pkg::hex_value(c);
  assign c_esc    = strdec_pkg::simple_escape(c);

  // State after the character itself, before any end-of-string handling.
  always_comb begin
    tk_mode = mode_q;
    tk_pv   = pv_q;
    tk_dt   = dt_q;
    tk_err  = err_q;
    if (item_i.has_char) begin
      case (mode_q)
        strdec_pkg::ModeEsc: begin
          tk_mode = strdec_pkg::ModeIdle;
          if (c_oct) begin
            tk_pv   = {5'd0, c[2:0]};
            tk_dt   = 2'd1;
            tk_mode = strdec_pkg::ModeOct;
          end else if (c == strdec_pkg::CharX) begin
            tk_mode = strdec_pkg::ModeHex0;
          end else if (!c_esc.ok) begin
            tk_err = 1'b1;
          end
        end
        strdec_pkg::ModeOct: begin
          if (c_oct) begin
            tk_pv = {pv_q[4:0], c[2:0]};
            if (dt_q == strdec_pkg::LastOctIdx) begin
              tk_mode = strdec_pkg::ModeIdle;
              tk_dt   = 2'd0;
            end else begin
              tk_dt = dt_q + 2'd1;
            end
          end else begin
            tk_dt   = 2'd0;
            tk_mode = c_bslash ? strdec_pkg::ModeEsc : strdec_pkg::ModeIdle;
          end
        end
        strdec_pkg::ModeHex0: begin
          if (c_hex.ok) begin
            tk_pv   = {4'd0, c_hex.val};
            tk_mode = strdec_pkg::ModeHex1;
          end else begin
            tk_err  = 1'b1;
            tk_mode = strdec_pkg::ModeIdle;
          end
        end
        strdec_pkg::ModeHex1: begin
          if (c_hex.ok) begin
            tk_mode = strdec_pkg::ModeIdle;
          end else begin
            tk_mode = c_bslash ? strdec_pkg::ModeEsc : strdec_pkg::ModeIdle;
          end
        end
        default: begin
          tk_mode = c_bslash ? strdec_pkg::ModeEsc : strdec_pkg::ModeIdle;
        end
      endcase
    end
  end

  // Next state: end of string returns everything to reset values.
  always_comb begin
    mode_d = mode_q;
    pv_d   = pv_q;
    dt_d   = dt_q;
    err_d  = err_q;
    if (accept_i) begin
      if (item_i.last) begin
        mode_d = strdec_pkg::ModeIdle;
        pv_d   = '0;
        dt_d   = '0;
        err_d  = 1'b0;
      end else begin
        mode_d = tk_mode;
        pv_d   = tk_pv;
        dt_d   = tk_dt;
        err_d  = tk_err;
      end
    end
  end

  // Command contents.
  always_comb begin
    cmd = '0;
    if (item_i.has_char) begin
      case (mode_q)
        strdec_pkg::ModeEsc: begin
          if (!c_oct && (c != strdec_pkg::CharX) && c_esc.ok) begin
            cmd.b0_vld = 1'b1;
            cmd.b0     = c_esc.val;
          end
        end
        strdec_pkg::ModeOct: begin
          if (c_oct) begin
            if (dt_q == strdec_pkg::LastOctIdx) begin
              cmd.b0_vld = 1'b1;
              cmd.b0     = {pv_q[4:0], c[2:0]};
            end
          end else begin
            cmd.b0_vld = 1'b1;
            cmd.b0     = pv_q;
            cmd.b1_vld = !c_bslash;
            cmd.b1     = c;
          end
        end
        strdec_pkg::ModeHex0: begin
          cmd.b0_vld = 1'b0;
        end
        strdec_pkg::ModeHex1: begin
          cmd.b0_vld = 1'b1;
          if (c_hex.ok) begin
            cmd.b0 = {pv_q[3:0], c_hex.val};
          end else begin
            cmd.b0     = pv_q;
            cmd.b1_vld = !c_bslash;
            cmd.b1     = c;
          end
        end
        default: begin
          cmd.b0_vld = !c_bslash;
          cmd.b0     = c;
        end
      endcase
    end
    // A pending octal or single-hex escape is flushed at the end; slot 0 is
    // always free in those modes.
    if (item_i.last) begin
      if ((tk_mode == strdec_pkg::ModeOct) || (tk_mode == strdec_pkg::ModeHex1)) begin
        cmd.b0_vld = 1'b1;
        cmd.b0     = tk_pv;
      end
      cmd.end_vld = 1'b1;
      cmd.fail    = tk_err || (tk_mode == strdec_pkg::ModeEsc) ||
                    (tk_mode == strdec_pkg::ModeHex0);
    end
    // Once failed, no more bytes for this string.
    if (err_q) begin
      cmd.b0_vld = 1'b0;
      cmd.b1_vld = 1'b0;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept_i && (cmd.b0_vld || cmd.b1_vld || cmd.end_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= strdec_pkg::ModeIdle;
      pv_q   <= '0;
      dt_q   <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pv_q   <= pv_d;
      dt_q   <= dt_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== sv/strdec_cmd_fifo.sv =====
// Small command queue between front and back of the escape decoder.
// Depends on strdec_pkg for the command type.
`timescale 1ns / 1ps

module strdec_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  strdec_pkg::cmd_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output strdec_pkg::cmd_t rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  strdec_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== sv/strdec_back.sv =====
// Back end: walks the slots of the head command into the output register
// one per cycle while it is empty or popped. Depends on strdec_pkg.
`timescale 1ns / 1ps

module strdec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  strdec_pkg::cmd_t      cmd_i,
  input  logic                  cmd_empty_i,
  output logic                  cmd_pop_o,
  output strdec_pkg::out_item_t res_o,
  output logic                  empty_o,
  input  logic                  pop_i
);

  logic [2:0]            done_q, done_d;
  logic                  out_vld_q, out_vld_d;
  strdec_pkg::out_item_t out_q, out_d;

  logic [2:0] pend, sel, rest;
  logic       load, emit;

  assign pend = cmd_empty_i ? 3'b000 :
                ({cmd_i.end_vld, cmd_i.b1_vld, cmd_i.b0_vld} & ~done_q);
  assign sel  = pend[0] ? 3'b001 : (pend[1] ? 3'b010 : (pend[2] ? 3'b100 : 3'b000));
  assign rest = pend & ~sel;
  assign load = !out_vld_q || pop_i;
  assign emit = load && (pend != 3'b000);

  assign cmd_pop_o = emit && (rest == 3'b000);

  always_comb begin
    done_d    = done_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (emit) begin
      out_vld_d = 1'b1;
      done_d    = (rest == 3'b000) ? 3'b000 : (done_q | sel);
      out_d     = '0;
      if (sel[0]) begin
        out_d.out_byte   = cmd_i.b0;
        out_d.byte_valid = 1'b1;
      end else if (sel[1]) begin
        out_d.out_byte   = cmd_i.b1;
        out_d.byte_valid = 1'b1;
      end else begin
        out_d.end_of_string = 1'b1;
        out_d.failed        = cmd_i.fail;
      end
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign res_o   = out_q;
  assign empty_o = !out_vld_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== sv/string_escape_decoder.sv =====
// Top level of the string escape decoder: front end, command queue, back end.
// Depends on strdec_pkg, strdec_front, strdec_cmd_fifo and strdec_back.
`timescale 1ns / 1ps

// Decodes the body of a C-style string literal, one raw character per
// request, into bytes. Octal escapes take one to three digits 0-7 and wrap
// to 8 bits; hex escapes are x plus one or two hex digits; the usual simple
// escapes are supported. A bad escape, a dangling backslash or a bare x
// marks the string failed: later bytes are dropped and the end result
// carries failed = 1. Each request yields zero to three results (a flushed
// escape byte, the character's own byte, the end result). Timing: a request
// is taken every cycle while full is low. The front end classifies it in the
// cycle it is pushed and writes at most one command into a CmdDepth-entry
// queue; the back end turns each command into results at one result per
// cycle through the output register while that register is empty or
// popped, so sustained throughput is one item per cycle as long as items
// average at most one result. A request's first result passes the command
// queue and then the output register before it reaches the result port.
module string_escape_decoder #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  strdec_pkg::in_item_t  item_i,
  input  logic                  push,
  output logic                  full,
  output strdec_pkg::out_item_t result_o,
  output logic                  empty,
  input  logic                  pop
);

  logic             accept;
  logic             cmd_push;
  strdec_pkg::cmd_t cmd_wdata;
  strdec_pkg::cmd_t cmd_head;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;

  // A request is taken whenever the command queue has room.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  strdec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .accept_i   (accept),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wdata)
  );

  strdec_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  strdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

`ifndef SYNTHESIS
  // Front end only writes a command when the queue had room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("command written into full queue");

  // Every queued command carries at least one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (cmd_wdata.b0_vld || cmd_wdata.b1_vld || cmd_wdata.end_vld))
    else $error("empty command queued");

  // An end result never also claims a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.end_of_string) |-> !result_o.byte_valid)
    else $error("end result with byte_valid set");

  // The back end only pops a command that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("pop from empty command queue");
`endif

endmodule
